// File: hdl/dvrt_pkg.sv
package dvrt_pkg;

   localparam int TableEntries = 64;
   localparam int IdxWidth = $clog2(TableEntries);
   localparam int CntWidth = IdxWidth + 1;
   localparam int EntryWidth = 64 * 4 + 19 + 32;

   localparam logic [1:0] MODE_UPSERT = 2'd0;
   localparam logic [1:0] MODE_POISON = 2'd1;
   localparam logic [1:0] MODE_GC = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [4:0] INFINITE_METRIC = 5'd16;
   localparam logic [4:0] DIRECT_NEIGHBOR = 5'h1f;

   localparam logic [0:0] CSR_GC_HOLD = 1'd0;

   typedef struct packed {
      logic [63:0] dest_high;
      logic [63:0] dest_low;
      logic [63:0] hop_high;
      logic [63:0] hop_low;
      logic        v6;
      logic [7:0]  plen;
      logic [4:0]  metric;
      logic [4:0]  nbr;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic               load;
      logic               rd_en;
      logic [IdxWidth-1:0] rd_addr;
      logic               wr_en;
      logic [IdxWidth-1:0] wr_addr;
      logic [1:0]         wr_sel;
   } ctrl_type;

   typedef struct packed {
      logic match;
      logic poison_hit;
      logic gc_drop;
      logic upd_protect;
      logic upd_refresh;
      logic upd_replace;
   } status_type;

   localparam logic [1:0] WSEL_NEW = 2'd0;
   localparam logic [1:0] WSEL_UPD = 2'd1;
   localparam logic [1:0] WSEL_POISON = 2'd2;
   localparam logic [1:0] WSEL_COPY = 2'd3;

endpackage

// File: hdl/dvrt_ram.sv
module dvrt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/dvrt_datapath.sv
module dvrt_datapath (
   input  logic                  clock,
   input  dvrt_pkg::ctrl_type    ctrl,
   input  logic                  req_is_ipv6,
   input  logic [63:0]           req_dest_high,
   input  logic [63:0]           req_dest_low,
   input  logic [7:0]            req_prefix_length,
   input  logic [63:0]           req_hop_high,
   input  logic [63:0]           req_hop_low,
   input  logic signed [7:0]     req_route_metric,
   input  logic signed [4:0]     req_source_neighbor,
   input  logic [31:0]           req_now_seconds,
   input  logic [15:0]           gc_hold,
   output dvrt_pkg::status_type  status
);
   dvrt_pkg::entry_type cmd_ff, cmd_in;
   dvrt_pkg::entry_type rd_entry, wr_entry;
   logic [4:0] met;
   logic [31:0] age;

   always_comb begin
      if (req_route_metric[7] || req_route_metric > 8'sd16) begin
         met = dvrt_pkg::INFINITE_METRIC;
      end else begin
         met = req_route_metric[4:0];
      end
      cmd_in.v6 = req_is_ipv6;
      cmd_in.dest_high = req_is_ipv6 ? req_dest_high : 64'd0;
      cmd_in.dest_low = req_is_ipv6 ? req_dest_low : {32'd0, req_dest_low[31:0]};
      cmd_in.hop_high = req_is_ipv6 ? req_hop_high : 64'd0;
      cmd_in.hop_low = req_is_ipv6 ? req_hop_low : {32'd0, req_hop_low[31:0]};
      cmd_in.plen = req_prefix_length;
      cmd_in.metric = met;
      cmd_in.nbr = req_source_neighbor;
      cmd_in.stamp = req_now_seconds;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= cmd_in;
      end
   end

   dvrt_ram #(.Width(dvrt_pkg::EntryWidth), .Depth(dvrt_pkg::TableEntries)) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (ctrl.wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      wr_entry = rd_entry;
      case (ctrl.wr_sel)
         dvrt_pkg::WSEL_NEW: begin
            wr_entry = cmd_ff;
         end
         dvrt_pkg::WSEL_UPD: begin
            if (!status.upd_refresh) begin
               wr_entry.hop_high = cmd_ff.hop_high;
               wr_entry.hop_low = cmd_ff.hop_low;
               wr_entry.metric = cmd_ff.metric;
               wr_entry.nbr = cmd_ff.nbr;
            end
            wr_entry.stamp = cmd_ff.stamp;
         end
         dvrt_pkg::WSEL_POISON: begin
            wr_entry.metric = dvrt_pkg::INFINITE_METRIC;
            wr_entry.stamp = cmd_ff.stamp;
         end
         default: begin
            wr_entry = rd_entry;
         end
      endcase
   end

   assign age = cmd_ff.stamp - rd_entry.stamp;

   always_comb begin
      status.match = rd_entry.v6 == cmd_ff.v6 && rd_entry.plen == cmd_ff.plen
                     && rd_entry.dest_high == cmd_ff.dest_high
                     && rd_entry.dest_low == cmd_ff.dest_low;
      status.poison_hit = rd_entry.nbr == cmd_ff.nbr
                          && rd_entry.metric < dvrt_pkg::INFINITE_METRIC;
      status.gc_drop = rd_entry.metric == dvrt_pkg::INFINITE_METRIC
                       && age >= {16'd0, gc_hold};
      status.upd_protect = rd_entry.nbr == dvrt_pkg::DIRECT_NEIGHBOR
                           && !cmd_ff.nbr[4] && cmd_ff.metric >= rd_entry.metric;
      status.upd_refresh = !status.upd_protect && rd_entry.hop_high == cmd_ff.hop_high
                           && rd_entry.hop_low == cmd_ff.hop_low
                           && rd_entry.metric == cmd_ff.metric
                           && rd_entry.nbr == cmd_ff.nbr;
      status.upd_replace = !status.upd_protect && !status.upd_refresh
                           && (rd_entry.nbr == cmd_ff.nbr
                               || cmd_ff.metric < rd_entry.metric);
   end
endmodule

// File: hdl/dvrt_control.sv
module dvrt_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_mode,
   input  dvrt_pkg::status_type  status,
   output dvrt_pkg::ctrl_type    ctrl,
   output logic                  busy,
   output logic                  done,
   output logic [6:0]            result_value,
   output logic                  table_full,
   output logic [6:0]            route_count,
   output logic                  table_changed
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   localparam int CW = dvrt_pkg::CntWidth;
   localparam int IW = dvrt_pkg::IdxWidth;

   logic [2:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] res_ff, res_in;
   logic full_ff, full_in;
   logic changed_ff, changed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         changed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         changed_ff <= changed_in;
      end
      mode_ff <= mode_in;
      scan_ff <= scan_in;
      kept_ff <= kept_in;
      res_ff <= res_in;
      full_ff <= full_in;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      kept_in = kept_ff;
      res_in = res_ff;
      full_in = full_ff;
      changed_in = changed_ff;
      ctrl = '0;
      ctrl.rd_addr = scan_ff[IW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               mode_in = req_mode;
               scan_in = '0;
               kept_in = '0;
               res_in = '0;
               full_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (mode_ff == dvrt_pkg::MODE_UNUSED) begin
               state_in = ST_DONE;
            end else if (scan_ff == count_ff) begin
               state_in = ST_DONE;
               if (mode_ff == dvrt_pkg::MODE_UPSERT) begin
                  if (count_ff == CW'(dvrt_pkg::TableEntries)) begin
                     full_in = 1'b1;
                  end else begin
                     ctrl.wr_en = 1'b1;
                     ctrl.wr_addr = count_ff[IW-1:0];
                     ctrl.wr_sel = dvrt_pkg::WSEL_NEW;
                     count_in = count_ff + 1'b1;
                     changed_in = 1'b1;
                     res_in = CW'(1);
                  end
               end else if (mode_ff == dvrt_pkg::MODE_GC) begin
                  count_in = kept_ff;
                  if (res_ff != '0) begin
                     changed_in = 1'b1;
                  end
               end
            end else begin
               ctrl.rd_en = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            scan_in = scan_ff + 1'b1;
            state_in = ST_READ;
            ctrl.wr_addr = scan_ff[IW-1:0];
            case (mode_ff)
               dvrt_pkg::MODE_UPSERT: begin
                  if (status.match) begin
                     state_in = ST_DONE;
                     ctrl.wr_sel = dvrt_pkg::WSEL_UPD;
                     ctrl.wr_en = status.upd_refresh || status.upd_replace;
                     if (status.upd_replace) begin
                        changed_in = 1'b1;
                        res_in = CW'(1);
                     end
                  end
               end
               dvrt_pkg::MODE_POISON: begin
                  ctrl.wr_sel = dvrt_pkg::WSEL_POISON;
                  if (status.poison_hit) begin
                     ctrl.wr_en = 1'b1;
                     changed_in = 1'b1;
                     res_in = res_ff + 1'b1;
                  end
               end
               default: begin
                  ctrl.wr_sel = dvrt_pkg::WSEL_COPY;
                  ctrl.wr_addr = kept_ff[IW-1:0];
                  if (status.gc_drop) begin
                     res_in = res_ff + 1'b1;
                  end else begin
                     ctrl.wr_en = kept_ff != scan_ff;
                     kept_in = kept_ff + 1'b1;
                  end
               end
            endcase
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;
   assign done = state_ff == ST_DONE;
   assign result_value = 7'(res_ff);
   assign table_full = full_ff;
   assign route_count = 7'(count_ff);
   assign table_changed = changed_ff;
endmodule

// File: hdl/distance_vector_route_table.sv
// Distance-vector route table, one command per start. An upsert, poison or garbage-collect
// command scans the stored entries one at a time through a table memory with one read and
// one write port, reading each entry and then evaluating it and writing it back; an upsert
// stops at its first match. busy stays high for the whole command; the result appears for
// exactly one cycle with rsp_valid and must be captured then.
module distance_vector_route_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic               req_is_ipv6,
   input  logic [63:0]        req_dest_high,
   input  logic [63:0]        req_dest_low,
   input  logic [7:0]         req_prefix_length,
   input  logic [63:0]        req_hop_high,
   input  logic [63:0]        req_hop_low,
   input  logic signed [7:0]  req_route_metric,
   input  logic signed [4:0]  req_source_neighbor,
   input  logic [31:0]        req_now_seconds,
   output logic               rsp_valid,
   output logic [6:0]         rsp_result_value,
   output logic               rsp_table_full,
   output logic [6:0]         rsp_route_count,
   output logic               rsp_table_changed,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   logic [15:0] gc_hold_ff;
   dvrt_pkg::ctrl_type ctrl;
   dvrt_pkg::status_type status;

   assign pready = 1'b1;
   assign prdata = (paddr[1:1] == dvrt_pkg::CSR_GC_HOLD) ? {16'd0, gc_hold_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_hold_ff <= 16'd120;
      end else if (psel && penable && pwrite && paddr[1:1] == dvrt_pkg::CSR_GC_HOLD) begin
         gc_hold_ff <= pwdata[15:0];
      end
   end

   dvrt_control u_control (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_mode      (req_mode),
      .status        (status),
      .ctrl          (ctrl),
      .busy          (busy),
      .done          (rsp_valid),
      .result_value  (rsp_result_value),
      .table_full    (rsp_table_full),
      .route_count   (rsp_route_count),
      .table_changed (rsp_table_changed)
   );

   dvrt_datapath u_datapath (
      .clock               (clock),
      .ctrl                (ctrl),
      .req_is_ipv6         (req_is_ipv6),
      .req_dest_high       (req_dest_high),
      .req_dest_low        (req_dest_low),
      .req_prefix_length   (req_prefix_length),
      .req_hop_high        (req_hop_high),
      .req_hop_low         (req_hop_low),
      .req_route_metric    (req_route_metric),
      .req_source_neighbor (req_source_neighbor),
      .req_now_seconds     (req_now_seconds),
      .gc_hold             (gc_hold_ff),
      .status              (status)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_route_count <= 7'd64)
      else $error("route count out of range");
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held longer than one cycle");
   a_changed_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_table_changed) |-> rsp_table_changed)
      else $error("changed flag cleared");
   a_full_only_upsert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_route_count == 7'd64 && rsp_result_value == 7'd0)
      else $error("table full with room");
endmodule

// File: tb/route_table_checker.sv
module route_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_mode,
   input  logic              req_is_ipv6,
   input  logic [63:0]       req_dest_high,
   input  logic [63:0]       req_dest_low,
   input  logic [7:0]        req_prefix_length,
   input  logic [63:0]       req_hop_high,
   input  logic [63:0]       req_hop_low,
   input  logic [7:0]        req_route_metric,
   input  logic [4:0]        req_source_neighbor,
   input  logic [31:0]       req_now_seconds,
   input  logic              rsp_valid,
   input  logic [6:0]        rsp_result_value,
   input  logic              rsp_table_full,
   input  logic [6:0]        rsp_route_count,
   input  logic              rsp_table_changed,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                pending,
   output int                fail_count
);
   typedef struct {
      logic [6:0] result_value;
      logic       table_full;
      logic [6:0] route_count;
      logic       table_changed;
   } route_outcome_type;

   route_outcome_type expected_results[$];

   logic [63:0] rt_dh[dvrt_pkg::TableEntries];
   logic [63:0] rt_dl[dvrt_pkg::TableEntries];
   logic [63:0] rt_hh[dvrt_pkg::TableEntries];
   logic [63:0] rt_hl[dvrt_pkg::TableEntries];
   logic        rt_v6[dvrt_pkg::TableEntries];
   logic [7:0]  rt_plen[dvrt_pkg::TableEntries];
   logic [4:0]  rt_metric[dvrt_pkg::TableEntries];
   logic [4:0]  rt_nbr[dvrt_pkg::TableEntries];
   logic [31:0] rt_stamp[dvrt_pkg::TableEntries];
   int          rt_count;
   logic        rt_changed;
   logic [15:0] hold_seconds;

   assign pending = expected_results.size();

   task automatic apply_route_command(output route_outcome_type o);
      logic [63:0] dh, dl, hh, hl;
      logic [4:0]  met, nb;
      logic [31:0] now;
      int          idx, kept, res;
      logic        full, same_hop;
      res = 0;
      full = 0;
      nb = req_source_neighbor;
      now = req_now_seconds;
      dh = req_is_ipv6 ? req_dest_high : 64'd0;
      dl = req_is_ipv6 ? req_dest_low : {32'd0, req_dest_low[31:0]};
      hh = req_is_ipv6 ? req_hop_high : 64'd0;
      hl = req_is_ipv6 ? req_hop_low : {32'd0, req_hop_low[31:0]};
      if (req_route_metric[7] || req_route_metric > 8'd16) met = dvrt_pkg::INFINITE_METRIC;
      else met = req_route_metric[4:0];
      case (req_mode)
         dvrt_pkg::MODE_UPSERT: begin
            idx = rt_count;
            for (int i = 0; i < rt_count; i++) begin
               if (rt_v6[i] == req_is_ipv6 && rt_plen[i] == req_prefix_length &&
                   rt_dh[i] == dh && rt_dl[i] == dl) begin
                  idx = i;
                  break;
               end
            end
            if (idx == rt_count) begin
               if (rt_count >= dvrt_pkg::TableEntries) begin
                  full = 1;
               end else begin
                  rt_dh[idx] = dh;
                  rt_dl[idx] = dl;
                  rt_hh[idx] = hh;
                  rt_hl[idx] = hl;
                  rt_v6[idx] = req_is_ipv6;
                  rt_plen[idx] = req_prefix_length;
                  rt_metric[idx] = met;
                  rt_nbr[idx] = nb;
                  rt_stamp[idx] = now;
                  rt_count++;
                  rt_changed = 1;
                  res = 1;
               end
            end else begin
               same_hop = rt_hh[idx] == hh && rt_hl[idx] == hl;
               if (rt_nbr[idx] == dvrt_pkg::DIRECT_NEIGHBOR && !nb[4] &&
                   met >= rt_metric[idx]) begin
               end else if (same_hop && rt_metric[idx] == met && rt_nbr[idx] == nb) begin
                  rt_stamp[idx] = now;
               end else if (rt_nbr[idx] == nb || met < rt_metric[idx]) begin
                  rt_hh[idx] = hh;
                  rt_hl[idx] = hl;
                  rt_metric[idx] = met;
                  rt_nbr[idx] = nb;
                  rt_stamp[idx] = now;
                  rt_changed = 1;
                  res = 1;
               end
            end
         end
         dvrt_pkg::MODE_POISON: begin
            for (int i = 0; i < rt_count; i++) begin
               if (rt_nbr[i] == nb && rt_metric[i] < dvrt_pkg::INFINITE_METRIC) begin
                  rt_metric[i] = dvrt_pkg::INFINITE_METRIC;
                  rt_stamp[i] = now;
                  rt_changed = 1;
                  res++;
               end
            end
         end
         dvrt_pkg::MODE_GC: begin
            kept = 0;
            for (int i = 0; i < rt_count; i++) begin
               if (rt_metric[i] == dvrt_pkg::INFINITE_METRIC &&
                   (now - rt_stamp[i]) >= {16'd0, hold_seconds}) begin
                  res++;
               end else begin
                  rt_dh[kept] = rt_dh[i];
                  rt_dl[kept] = rt_dl[i];
                  rt_hh[kept] = rt_hh[i];
                  rt_hl[kept] = rt_hl[i];
                  rt_v6[kept] = rt_v6[i];
                  rt_plen[kept] = rt_plen[i];
                  rt_metric[kept] = rt_metric[i];
                  rt_nbr[kept] = rt_nbr[i];
                  rt_stamp[kept] = rt_stamp[i];
                  kept++;
               end
            end
            rt_count = kept;
            if (res > 0) rt_changed = 1;
         end
         default: begin
         end
      endcase
      o.result_value = res[6:0];
      o.table_full = full;
      o.route_count = rt_count[6:0];
      o.table_changed = rt_changed;
   endtask

   always @(posedge clock) begin
      route_outcome_type o;
      if (reset) begin
         rt_count = 0;
         rt_changed = 0;
         hold_seconds = 16'd120;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr == {dvrt_pkg::CSR_GC_HOLD, 1'b0})
            hold_seconds = pwdata[15:0];
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer");
               fail_count++;
            end else begin
               o = expected_results.pop_front();
               if (rsp_result_value !== o.result_value) begin
                  $error("result_value expected %0d got %0d", o.result_value, rsp_result_value);
                  fail_count++;
               end
               if (rsp_table_full !== o.table_full) begin
                  $error("table_full expected %0d got %0d", o.table_full, rsp_table_full);
                  fail_count++;
               end
               if (rsp_route_count !== o.route_count) begin
                  $error("route_count expected %0d got %0d", o.route_count, rsp_route_count);
                  fail_count++;
               end
               if (rsp_table_changed !== o.table_changed) begin
                  $error("table_changed expected %0d got %0d", o.table_changed,
                         rsp_table_changed);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_route_command(o);
            expected_results.push_back(o);
         end
      end
   end
endmodule

// File: tb/distance_vector_route_table_test.sv
module distance_vector_route_table_test;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [1:0]        req_mode = 0;
   logic              req_is_ipv6 = 0;
   logic [63:0]       req_dest_high = 0;
   logic [63:0]       req_dest_low = 0;
   logic [7:0]        req_prefix_length = 0;
   logic [63:0]       req_hop_high = 0;
   logic [63:0]       req_hop_low = 0;
   logic signed [7:0] req_route_metric = 0;
   logic signed [4:0] req_source_neighbor = 0;
   logic [31:0]       req_now_seconds = 0;
   logic              rsp_valid;
   logic [6:0]        rsp_result_value;
   logic              rsp_table_full;
   logic [6:0]        rsp_route_count;
   logic              rsp_table_changed;
   logic              psel = 0;
   logic              penable = 0;
   logic              pwrite = 0;
   logic [1:0]        paddr = 0;
   logic [31:0]       pwdata = 0;
   logic [31:0]       prdata;
   logic              pready;
   int                pending;
   int                fail_count;
   int                stall_cycles = 0;

   int          idle_pct;
   logic [31:0] clock_s;
   int          pool_n;
   logic [63:0] pool_dh[128];
   logic [63:0] pool_dl[128];
   logic        pool_v6[128];
   logic [7:0]  pool_plen[128];
   logic [63:0] hop_h[4];
   logic [63:0] hop_l[4];

   distance_vector_route_table u_top (.*);

   route_table_checker u_checker (
      .clock, .reset, .start, .busy, .req_mode, .req_is_ipv6, .req_dest_high,
      .req_dest_low, .req_prefix_length, .req_hop_high, .req_hop_low,
      .req_route_metric, .req_source_neighbor, .req_now_seconds, .rsp_valid,
      .rsp_result_value, .rsp_table_full, .rsp_route_count, .rsp_table_changed,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .fail_count
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 4000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(input logic [1:0] m, input logic v6, input logic [63:0] dh,
                       input logic [63:0] dl, input logic [7:0] plen, input logic [63:0] hh,
                       input logic [63:0] hl, input logic [7:0] met, input logic [4:0] nb,
                       input logic [31:0] now);
      int gap;
      req_mode <= m;
      req_is_ipv6 <= v6;
      req_dest_high <= dh;
      req_dest_low <= dl;
      req_prefix_length <= plen;
      req_hop_high <= hh;
      req_hop_low <= hl;
      req_route_metric <= met;
      req_source_neighbor <= nb;
      req_now_seconds <= now;
      start <= 1;
      do @(posedge clock); while (busy);
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_hold(input logic [31:0] v);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {dvrt_pkg::CSR_GC_HOLD, 1'b0};
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic new_pool(input int n);
      pool_n = n;
      for (int i = 0; i < n; i++) begin
         pool_dh[i] = rand64();
         pool_dl[i] = rand64();
         pool_v6[i] = 1'($urandom_range(1));
         pool_plen[i] = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(128));
      end
      for (int i = 0; i < 4; i++) begin
         hop_h[i] = rand64();
         hop_l[i] = rand64();
      end
   endtask

   task automatic send_random();
      int          p, r, h;
      logic [1:0]  m;
      logic [7:0]  met;
      logic [4:0]  nb;
      logic        v6;
      r = $urandom_range(99);
      if (r < 85) clock_s = clock_s + $urandom_range(40);
      else if (r < 95) clock_s = clock_s + $urandom_range(2000);
      else clock_s = clock_s + $urandom_range(100000);
      if ($urandom_range(99) < 8) begin
         send(2'($urandom), 1'($urandom), rand64(), rand64(), 8'($urandom), rand64(),
              rand64(), 8'($urandom), 5'($urandom), $urandom);
         return;
      end
      r = $urandom_range(99);
      m = r < 72 ? dvrt_pkg::MODE_UPSERT : r < 84 ? dvrt_pkg::MODE_POISON :
          r < 96 ? dvrt_pkg::MODE_GC : dvrt_pkg::MODE_UNUSED;
      p = $urandom_range(pool_n - 1);
      h = $urandom_range(3);
      v6 = $urandom_range(9) == 0 ? !pool_v6[p] : pool_v6[p];
      met = $urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(16));
      r = $urandom_range(99);
      nb = r < 15 ? 5'h1f : r < 85 ? 5'($urandom_range(3)) : 5'($urandom);
      send(m, v6, pool_dh[p], pool_dl[p], pool_plen[p], hop_h[h], hop_l[h], met, nb,
           clock_s);
   endtask

   initial begin
      logic [63:0] ones;
      logic [31:0] holds[6];
      int          pools[6];
      int          idles[6];
      ones = '1;
      idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(dvrt_pkg::MODE_UPSERT, 1, ones, ones, 8'd128, ones, ones, 8'd127, 5'h1f, 32'd10);
      send(dvrt_pkg::MODE_UPSERT, 1, ones, ones, 8'd128, ones, ones, 8'd127, 5'h1f, 32'd20);
      send(dvrt_pkg::MODE_UPSERT, 1, ones, ones, 8'd128, 64'd1, 64'd1, 8'd16, 5'd2, 32'd30);
      send(dvrt_pkg::MODE_UPSERT, 1, ones, ones, 8'd128, 64'd1, 64'd1, 8'd3, 5'd2, 32'd40);
      send(dvrt_pkg::MODE_UPSERT, 1, ones, ones, 8'd128, 64'd1, 64'd1, 8'd9, 5'd2, 32'd50);
      send(dvrt_pkg::MODE_UPSERT, 1, ones, ones, 8'd128, 64'd2, 64'd2, 8'd9, 5'd5, 32'd60);
      send(dvrt_pkg::MODE_UPSERT, 0, ones, 64'h1234_5678_0a00_0000, 8'd8, ones, ones, 8'h80,
           5'd1, 32'd70);
      send(dvrt_pkg::MODE_UPSERT, 0, 64'd0, 64'h0a00_0000, 8'd8, 64'd0, 64'hffff_ffff, 8'd0,
           5'd1, 32'd80);
      send(dvrt_pkg::MODE_UPSERT, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'h1f, 32'd90);
      send(dvrt_pkg::MODE_UPSERT, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd7, 8'd0, 5'd4, 32'd95);
      send(dvrt_pkg::MODE_UPSERT, 0, 64'd0, 64'd0, 8'd255, 64'd0, 64'd7, 8'd17, 5'h10,
           32'd99);
      send(dvrt_pkg::MODE_UPSERT, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd7, 8'd5, 5'h10, 32'd100);
      send(dvrt_pkg::MODE_POISON, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'd1, 32'd100);
      send(dvrt_pkg::MODE_POISON, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'd1, 32'd110);
      send(dvrt_pkg::MODE_UNUSED, 1, ones, ones, 8'd128, ones, ones, 8'd1, 5'd2, 32'd120);
      send(dvrt_pkg::MODE_GC, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'd0, 32'd200);
      send(dvrt_pkg::MODE_GC, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'd0, 32'd330);
      send(dvrt_pkg::MODE_POISON, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'h1f,
           32'hffff_fff0);
      send(dvrt_pkg::MODE_GC, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'd0, 32'd100);
      send(dvrt_pkg::MODE_GC, 0, 64'd0, 64'd0, 8'd0, 64'd0, 64'd0, 8'd0, 5'd0,
           32'hffff_ffff);
      drain();

      holds = '{32'hffff_0001, 32'h0000_ffff, 32'd0, 32'd120, 32'd300, 32'd7};
      pools = '{90, 10, 12, 80, 8, 16};
      idles = '{0, 82, 0, 12, 82, 0};
      for (int ph = 0; ph < 6; ph++) begin
         write_hold(ph == 5 ? $urandom : holds[ph]);
         new_pool(pools[ph]);
         clock_s = $urandom_range(1) ? $urandom : 32'hffff_f000;
         idle_pct = idles[ph];
         for (int k = 0; k < 222; k++) begin
            send_random();
            if (k == 111 && ph == 1) begin
               start <= 0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
